@@ hdl/pci_pkg.sv @@
`default_nettype none
package pci_pkg;

    localparam int PALETTE_DEPTH  = 4096;
    localparam int ADDR_W         = $clog2(PALETTE_DEPTH);
    localparam int CNT_W          = $clog2(PALETTE_DEPTH + 1);
    localparam int COLOR_W        = 48;
    localparam int ALPHA_W        = 16;
    localparam int OPAQUE_BIT     = 15;
    localparam int INDEX_W        = 12;
    localparam int COUNT_W        = 13;
    localparam int ERROR_W        = 3;
    localparam int TWO_CHAR_LIMIT = 64;

    localparam logic FUNC_MAP    = 1'b0;
    localparam logic FUNC_DEFINE = 1'b1;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [COLOR_W-1:0] color_t;
    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [ERROR_W-1:0] {
        ERR_OK         = 3'd0,
        ERR_FULL       = 3'd1,
        ERR_ABSENT     = 3'd2,
        ERR_NO_TRANSP  = 3'd3,
        ERR_DUP_TRANSP = 3'd4
    } err_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Search request from the sequencer; held stable for the whole search.
    typedef struct packed {
        logic   start;
        color_t color;
        cnt_t   count;
        logic   tvalid;
        addr_t  tidx;
    } scan_req_t;

    typedef struct packed {
        logic  done;
        logic  hit;
        addr_t hit_idx;
    } scan_rsp_t;

endpackage
`default_nettype wire

@@ hdl/pci_ram.sv @@
`default_nettype none
module pci_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ hdl/pci_scan.sv @@
`default_nettype none
module pci_scan (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire pci_pkg::scan_req_t req,
    input  wire pci_pkg::color_t    rd_data,
    output logic                    rd_en,
    output pci_pkg::addr_t          rd_addr,
    output pci_pkg::scan_rsp_t      rsp
);

    logic            active_reg, active_next;
    logic            cmp_valid_reg, cmp_valid_next;
    pci_pkg::cnt_t   issue_reg, issue_next;
    pci_pkg::addr_t  cmp_addr_reg, cmp_addr_next;
    logic            issue_more;
    logic            match;

    // One address issued per cycle; its stored color is compared in the cycle after.
    always_comb begin
        issue_more = active_reg && (issue_reg < req.count);
        match      = cmp_valid_reg && (rd_data == req.color)
                     && !(req.tvalid && (cmp_addr_reg == req.tidx));
        rsp.done    = active_reg && (match || (!issue_more && !cmp_valid_reg));
        rsp.hit     = match;
        rsp.hit_idx = cmp_addr_reg;
        rd_en       = issue_more;
        rd_addr     = issue_reg[pci_pkg::ADDR_W-1:0];

        active_next    = active_reg;
        cmp_valid_next = cmp_valid_reg;
        issue_next     = issue_reg;
        cmp_addr_next  = cmp_addr_reg;
        if (req.start) begin
            active_next    = 1'b1;
            cmp_valid_next = 1'b0;
            issue_next     = '0;
        end else if (rsp.done) begin
            active_next    = 1'b0;
            cmp_valid_next = 1'b0;
        end else if (active_reg) begin
            cmp_valid_next = issue_more;
            cmp_addr_next  = issue_reg[pci_pkg::ADDR_W-1:0];
            if (issue_more) begin
                issue_next = issue_reg + pci_pkg::cnt_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            cmp_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            cmp_valid_reg <= cmp_valid_next;
        end
        issue_reg    <= issue_next;
        cmp_addr_reg <= cmp_addr_next;
    end

endmodule
`default_nettype wire

@@ hdl/palette_color_indexer.sv @@
`default_nettype none
// Defines and transparent pixels are settled in ST_DECIDE, their result registered and then
// loaded into the output register from ST_DONE. Opaque pixels walk the palette in ST_SCAN at
// one compare per cycle, a hit ending the walk and a miss reading all entry_count entries, the
// single read port of the palette memory and its comparator setting the pace.
// A new request is taken only in ST_IDLE, after the previous one has left ST_DONE; the next
// request is taken while the previous result still waits in the output register.
// Reset (synchronous, aresetn low): empty palette, no transparent entry, auto mode.
module palette_color_indexer (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // request channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_func,
    input  wire logic [pci_pkg::COLOR_W-1:0]   s_color,
    input  wire logic [pci_pkg::ALPHA_W-1:0]   s_alpha,
    input  wire logic                          s_transparent_entry,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [pci_pkg::INDEX_W-1:0]        m_index,
    output logic                               m_new_entry,
    output logic [pci_pkg::COUNT_W-1:0]        m_entry_count,
    output logic                               m_two_char_codes,
    output logic [pci_pkg::ERROR_W-1:0]        m_error,
    // configuration: fixed_palette
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          cfg_wdata
);

    // Sequencer and palette bookkeeping
    pci_pkg::state_t state_reg, state_next;
    pci_pkg::cnt_t   count_reg, count_next;
    logic            tvalid_reg, tvalid_next;
    pci_pkg::addr_t  tidx_reg, tidx_next;
    logic            fixed_reg;

    // Captured request
    logic            func_reg;
    pci_pkg::color_t color_reg;
    logic            opaque_reg;
    logic            tdef_reg;

    // Result waiting for the output register
    pci_pkg::addr_t  res_index_reg, res_index_next;
    logic            res_new_reg, res_new_next;
    pci_pkg::err_t   res_err_reg, res_err_next;

    // Output register
    logic            m_valid_reg, m_valid_next;
    pci_pkg::index_t m_index_reg;
    logic            m_new_reg;
    pci_pkg::count_t m_count_reg;
    logic            m_two_reg;
    pci_pkg::err_t   m_err_reg;
    logic            out_load;

    // Palette memory and search unit
    logic               ram_we;
    pci_pkg::color_t    ram_rdata;
    logic               ram_re;
    pci_pkg::addr_t     ram_raddr;
    pci_pkg::scan_req_t scan_req;
    pci_pkg::scan_rsp_t scan_rsp;

    logic               full;
    logic               accept;

    assign s_ready   = (state_reg == pci_pkg::ST_IDLE);
    assign cfg_ready = (state_reg == pci_pkg::ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign full      = (count_reg == pci_pkg::cnt_t'(pci_pkg::PALETTE_DEPTH));

    pci_ram #(
        .WIDTH(pci_pkg::COLOR_W),
        .DEPTH(pci_pkg::PALETTE_DEPTH)
    ) u_palette (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(count_reg[pci_pkg::ADDR_W-1:0]),
        .wdata(color_reg),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    pci_scan u_scan (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (scan_req),
        .rd_data(ram_rdata),
        .rd_en  (ram_re),
        .rd_addr(ram_raddr),
        .rsp    (scan_rsp)
    );

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        tvalid_next    = tvalid_reg;
        tidx_next      = tidx_reg;
        res_index_next = res_index_reg;
        res_new_next   = res_new_reg;
        res_err_next   = res_err_reg;
        ram_we         = 1'b0;
        out_load       = 1'b0;

        // Hold the search request stable for the whole search.
        scan_req.start  = 1'b0;
        scan_req.color  = color_reg;
        scan_req.count  = count_reg;
        scan_req.tvalid = tvalid_reg;
        scan_req.tidx   = tidx_reg;

        unique case (state_reg)
            pci_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = pci_pkg::ST_DECIDE;
                end
            end
            pci_pkg::ST_DECIDE: begin
                // Everything except an opaque pixel is settled right here.
                res_index_next = '0;
                res_new_next   = 1'b0;
                res_err_next   = pci_pkg::ERR_OK;
                state_next     = pci_pkg::ST_DONE;
                if (func_reg == pci_pkg::FUNC_DEFINE) begin
                    if (full) begin
                        res_err_next = pci_pkg::ERR_FULL;
                    end else if (tdef_reg && tvalid_reg) begin
                        res_err_next = pci_pkg::ERR_DUP_TRANSP;
                    end else begin
                        if (tdef_reg) begin
                            tvalid_next = 1'b1;
                            tidx_next   = count_reg[pci_pkg::ADDR_W-1:0];
                        end else begin
                            ram_we = 1'b1;
                        end
                        count_next     = count_reg + pci_pkg::cnt_t'(1);
                        res_index_next = count_reg[pci_pkg::ADDR_W-1:0];
                        res_new_next   = 1'b1;
                    end
                end else if (!opaque_reg) begin
                    if (tvalid_reg) begin
                        res_index_next = tidx_reg;
                    end else if (fixed_reg) begin
                        res_err_next = pci_pkg::ERR_NO_TRANSP;
                    end else if (full) begin
                        res_err_next = pci_pkg::ERR_FULL;
                    end else begin
                        // Create the transparent entry on first use.
                        tvalid_next    = 1'b1;
                        tidx_next      = count_reg[pci_pkg::ADDR_W-1:0];
                        count_next     = count_reg + pci_pkg::cnt_t'(1);
                        res_index_next = count_reg[pci_pkg::ADDR_W-1:0];
                        res_new_next   = 1'b1;
                    end
                end else begin
                    scan_req.start = 1'b1;
                    state_next     = pci_pkg::ST_SCAN;
                end
            end
            pci_pkg::ST_SCAN: begin
                if (scan_rsp.done) begin
                    state_next = pci_pkg::ST_DONE;
                    if (scan_rsp.hit) begin
                        res_index_next = scan_rsp.hit_idx;
                    end else if (fixed_reg) begin
                        res_err_next = pci_pkg::ERR_ABSENT;
                    end else if (full) begin
                        res_err_next = pci_pkg::ERR_FULL;
                    end else begin
                        // Append the unseen color at the end of the palette.
                        ram_we         = 1'b1;
                        count_next     = count_reg + pci_pkg::cnt_t'(1);
                        res_index_next = count_reg[pci_pkg::ADDR_W-1:0];
                        res_new_next   = 1'b1;
                    end
                end
            end
            pci_pkg::ST_DONE: begin
                // Hold the result until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = pci_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pci_pkg::ST_IDLE;
            end
        endcase

        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pci_pkg::ST_IDLE;
            count_reg   <= '0;
            tvalid_reg  <= 1'b0;
            tidx_reg    <= '0;
            fixed_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            tvalid_reg  <= tvalid_next;
            tidx_reg    <= tidx_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                fixed_reg <= cfg_wdata;
            end
        end

        // Capture the request payload.
        if (accept) begin
            func_reg   <= s_func;
            color_reg  <= s_color;
            opaque_reg <= s_alpha[pci_pkg::OPAQUE_BIT];
            tdef_reg   <= s_transparent_entry;
        end

        res_index_reg <= res_index_next;
        res_new_reg   <= res_new_next;
        res_err_reg   <= res_err_next;

        // Report the palette state as it stands after the item.
        if (out_load) begin
            m_index_reg <= pci_pkg::index_t'(res_index_reg);
            m_new_reg   <= res_new_reg;
            m_count_reg <= pci_pkg::count_t'(count_reg);
            m_two_reg   <= !fixed_reg && (count_reg > pci_pkg::TWO_CHAR_LIMIT);
            m_err_reg   <= res_err_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_index          = m_index_reg;
    assign m_new_entry      = m_new_reg;
    assign m_entry_count    = m_count_reg;
    assign m_two_char_codes = m_two_reg;
    assign m_error          = m_err_reg;

endmodule
`default_nettype wire

@@ hdl/pci_checker.sv @@
`default_nettype none
module pci_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [pci_pkg::INDEX_W-1:0]   m_index,
    input wire logic                          m_new_entry,
    input wire logic [pci_pkg::COUNT_W-1:0]   m_entry_count,
    input wire logic                          m_two_char_codes,
    input wire logic [pci_pkg::ERROR_W-1:0]   m_error
);

    // No result right after reset.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_index) && $stable(m_error)
            && $stable(m_entry_count))
        else $error("stalled result changed");

    // A failed request neither appends nor reports an index.
    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_error != pci_pkg::ERR_OK) |-> !m_new_entry && (m_index == '0))
        else $error("error result carries index or new entry");

    // An appended entry is always the last one in the palette.
    a_new_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_new_entry |-> (m_entry_count != '0)
            && (m_index == m_entry_count[pci_pkg::INDEX_W-1:0] - 1'b1))
        else $error("new entry index does not match entry count");

    // Two-character codes only past the threshold.
    a_two_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_two_char_codes |-> (m_entry_count > pci_pkg::TWO_CHAR_LIMIT))
        else $error("two-character codes below threshold");

endmodule

bind palette_color_indexer pci_checker u_pci_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_index         (m_index),
    .m_new_entry     (m_new_entry),
    .m_entry_count   (m_entry_count),
    .m_two_char_codes(m_two_char_codes),
    .m_error         (m_error)
);
`default_nettype wire
